// ===== hw/rtl/ledsd_pkg.sv =====
// Shared types and constants for the addressable LED strip driver.
`default_nettype none

package ledsd_pkg;

  // Operation codes of an input word
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Status codes of a result word
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_RANGE   = 2'd1;
  localparam logic [1:0] STATUS_PENDING = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LED_COUNT   = 2'd0;
  localparam logic [1:0] CFG_ONE_DUTY    = 2'd1;
  localparam logic [1:0] CFG_ZERO_DUTY   = 2'd2;
  localparam logic [1:0] CFG_RESET_SLOTS = 2'd3;

  // Configuration reset values
  localparam logic [6:0]  LED_COUNT_RST   = 7'd1;
  localparam logic [15:0] ONE_DUTY_RST    = 16'd60;
  localparam logic [15:0] ZERO_DUTY_RST   = 16'd30;
  localparam logic [7:0]  RESET_SLOTS_RST = 8'd64;

  // 32 bits per LED, sent MSB first
  localparam int         LED_SHIFT = 5;
  localparam logic [4:0] LED_MSB   = 5'd31;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  first_index;
    logic [7:0]  last_index;
    logic [31:0] color_grbw;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] duty;
    logic        slot_valid;
    logic        frame_end;
    logic        sending;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_READ,
    ST_DONE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic fill;
    logic read;
    logic deliver;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_start;
    logic tick_read;
    logic fill_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/addressable_led_strip_driver_top.sv =====
// Top level of the addressable LED strip driver.
// Flow: a word is captured and decoded, then for an active tick its slot is read
// from the table or for a fill the table is written one entry per cycle, and the
// result is loaded into the output register once that register is free. The
// step-by-step controller takes no new word until the last one is delivered.
// Reset: frame idle, configuration at defaults, table entries read as zero.
`default_nettype none

module addressable_led_strip_driver_top #(
  parameter int MAX_LEDS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ledsd_pkg::in_item_t  in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ledsd_pkg::out_item_t      out_word
);

  import ledsd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ledsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ledsd_dpath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ledsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ledsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ledsd_ctrl.sv =====
// Sequencing state machine of the LED strip driver.
`default_nettype none

module ledsd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ledsd_pkg::dp_sts_t sts,
  output ledsd_pkg::dp_cmd_t     cmd
);

  import ledsd_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.fill_start) begin
          state_next = ST_FILL;
        end else if (sts.tick_read) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_done) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.deliver = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ledsd_dpath.sv =====
// Datapath: configuration, color table, frame state and result register.
`default_nettype none

module ledsd_dpath #(
  parameter int MAX_LEDS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  input  wire ledsd_pkg::in_item_t in_word,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output ledsd_pkg::out_item_t     out_word,
  input  wire ledsd_pkg::dp_cmd_t  cmd,
  output ledsd_pkg::dp_sts_t       sts
);

  import ledsd_pkg::*;

  localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int POS_W  = $clog2(MAX_LEDS * 32 + 256);

  // Configuration
  logic [6:0]  led_count;
  logic [15:0] one_duty;
  logic [15:0] zero_duty;
  logic [7:0]  reset_slots;

  // Held input word and frame state
  in_item_t          item;
  logic              frame_pending;
  logic              frame_active;
  logic [POS_W-1:0]  slot_position;
  logic [ADDR_W-1:0] fill_cnt;
  logic [MAX_LEDS-1:0] ent_set;

  // Tick scratch
  logic              rd_in_bits;
  logic              rd_set;
  logic [4:0]        rd_bit;
  logic [31:0]       ram_rdata;

  // Staged result
  out_item_t         res;

  // Decode signals
  logic [7:0]        n_eff;
  logic              first_ok;
  logic              last_ok;
  logic              reversed;
  logic              tick_active;
  logic [POS_W-1:0]  bits_total;
  logic [POS_W-1:0]  len_raw;
  logic [POS_W-1:0]  len_eff;
  logic [POS_W-1:0]  p_inc;
  logic              last_slot;
  logic              in_bits;
  logic              range_err;
  logic              req_frame;
  logic [1:0]        status_now;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic              led_bit;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count   <= LED_COUNT_RST;
      one_duty    <= ONE_DUTY_RST;
      zero_duty   <= ZERO_DUTY_RST;
      reset_slots <= RESET_SLOTS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LED_COUNT:   led_count   <= cfg_data[6:0];
        CFG_ONE_DUTY:    one_duty    <= cfg_data;
        CFG_ZERO_DUTY:   zero_duty   <= cfg_data;
        CFG_RESET_SLOTS: reset_slots <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_word;
    end
  end

  // Range checks and frame geometry
  always_comb begin
    n_eff       = ({1'b0, led_count} > 8'(MAX_LEDS)) ? 8'(MAX_LEDS) : {1'b0, led_count};
    first_ok    = item.first_index < n_eff;
    last_ok     = item.last_index < n_eff;
    reversed    = item.first_index > item.last_index;
    tick_active = (item.operation == OP_TICK) && frame_active;
    bits_total  = POS_W'(n_eff) << LED_SHIFT;
    len_raw     = bits_total + POS_W'(reset_slots);
    len_eff     = (len_raw == '0) ? POS_W'(1) : len_raw;
    p_inc       = slot_position + POS_W'(1);
    last_slot   = p_inc >= len_eff;
    in_bits     = slot_position < bits_total;
  end

  // Frame requests and status
  always_comb begin
    range_err = cmd.decode &&
                (((item.operation == OP_WRITE) && !first_ok) ||
                 ((item.operation == OP_FILL) && !(first_ok && last_ok)));
    req_frame = (cmd.decode && (item.operation == OP_WRITE) && first_ok) ||
                (cmd.decode && (item.operation == OP_FILL) && first_ok && last_ok &&
                 reversed) ||
                (cmd.fill && sts.fill_done);
    status_now = STATUS_OK;
    if (range_err) begin
      status_now = STATUS_RANGE;
    end else if (req_frame && frame_pending) begin
      status_now = STATUS_PENDING;
    end
  end

  // Table ports
  always_comb begin
    ram_we    = (cmd.decode && (item.operation == OP_WRITE) && first_ok) || cmd.fill;
    ram_waddr = cmd.fill ? fill_cnt : item.first_index[ADDR_W-1:0];
    ram_re    = cmd.decode && tick_active && in_bits;
    ram_raddr = ADDR_W'(slot_position >> LED_SHIFT);
  end

  ledsd_ram #(
    .WIDTH (32),
    .DEPTH (MAX_LEDS),
    .AW    (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.color_grbw),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Mark written entries; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_set <= '0;
    end else if (ram_we) begin
      ent_set[ram_waddr] <= 1'b1;
    end
  end

  // Fill address counter
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      fill_cnt <= item.first_index[ADDR_W-1:0];
    end else if (cmd.fill) begin
      fill_cnt <= fill_cnt + ADDR_W'(1);
    end
  end

  // Frame state: start, advance, repeat or stop
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pending <= 1'b0;
      frame_active  <= 1'b0;
      slot_position <= '0;
    end else if (req_frame) begin
      if (!frame_pending) begin
        frame_pending <= 1'b1;
        if (!frame_active) begin
          frame_active  <= 1'b1;
          slot_position <= '0;
        end
      end
    end else if (cmd.decode && tick_active) begin
      if (last_slot) begin
        slot_position <= '0;
        if (frame_pending) begin
          frame_pending <= 1'b0;
        end else begin
          frame_active <= 1'b0;
        end
      end else begin
        slot_position <= p_inc;
      end
    end
  end

  // Hold what the read cycle needs
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      rd_in_bits <= in_bits;
      rd_bit     <= slot_position[4:0];
      if (tick_active && in_bits) begin
        rd_set <= ent_set[ram_raddr];
      end else begin
        rd_set <= 1'b0;
      end
    end
  end

  assign led_bit = rd_set && ram_rdata[LED_MSB - rd_bit];

  // Build the result; a granted frame request counts as sending already
  always_ff @(posedge clk) begin
    if (cmd.decode || (cmd.fill && sts.fill_done)) begin
      res.status <= status_now;
    end
    if (cmd.decode) begin
      res.duty       <= '0;
      res.slot_valid <= tick_active;
      res.frame_end  <= tick_active && last_slot;
    end else if (cmd.read) begin
      if (rd_in_bits) begin
        res.duty <= led_bit ? one_duty : zero_duty;
      end else begin
        res.duty <= '0;
      end
    end
    res.sending <= frame_active || req_frame;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_word <= res;
    end
  end

  // Status back to the controller
  always_comb begin
    sts.fill_start = (item.operation == OP_FILL) && first_ok && last_ok && !reversed;
    sts.tick_read  = tick_active;
    sts.fill_done  = fill_cnt == item.last_index[ADDR_W-1:0];
    sts.out_free   = !out_valid || !out_stall;
  end

  // A pending frame always has a frame running
  a_pending_active: assert property (@(posedge clk) disable iff (rst)
    frame_pending |-> frame_active)
    else $error("frame pending while no frame active");

  // Frame end only on a real slot
  a_end_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.frame_end) |-> out_word.slot_valid)
    else $error("frame end without slot");

  // Errors never come from a tick
  a_err_no_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_word.status != STATUS_OK)) |-> !out_word.slot_valid)
    else $error("error status on a slot word");

  // Nonzero duty only in a slot
  a_duty_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_word.duty != '0)) |-> out_word.slot_valid)
    else $error("duty outside a slot");

endmodule

`default_nettype wire
